// ===== sv/pcanc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCA projection nearest centroid package
// Shared constants, codes, operation word and helper functions.
// ----------------------------------------------------------------------------
package pcanc_pkg;

	localparam int DEF_MAX_DIMS       = 512;
	localparam int DEF_MAX_COMPONENTS = 8;
	localparam int DEF_MAX_CLUSTERS   = 8;

	localparam int IDX_W = 12;
	localparam int VAL_W = 24;
	localparam int CFG_DATA_W = 10;

	typedef enum logic [1:0] {
		CMD_MEAN   = 2'd0,
		CMD_WEIGHT = 2'd1,
		CMD_CENT   = 2'd2,
		CMD_SAMPLE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_DIMS     = 2'd0,
		CFG_COMPS    = 2'd1,
		CFG_CLUSTERS = 2'd2,
		CFG_NONE     = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [9:0] dims;
		logic [3:0] comps;
		logic [3:0] clusters;
	} cfg_t;

	// One classified word passed from the front to the back.
	typedef struct packed {
		cmd_t                    kind;
		logic [IDX_W-1:0]        addr;
		logic signed [VAL_W-1:0] data;
		logic                    in_range;
		logic                    last;
	} op_t;

	function automatic logic signed [15:0] sat16(input logic signed [VAL_W-1:0] v);
		logic signed [15:0] r;
		if (v > 24'sd32767) r = 16'sh7fff;
		else if (v < -24'sd32768) r = 16'sh8000;
		else r = v[15:0];
		return r;
	endfunction

	// Round half up to Q11.12, then saturate to 24 bits.
	function automatic logic signed [23:0] to_q11_12(input logic signed [47:0] s);
		logic signed [48:0] t;
		logic signed [36:0] q;
		logic signed [23:0] r;
		t = 49'(s) + 49'sd2048;
		q = 37'(t >>> 12);
		if (q > 37'sd8388607) r = 24'sh7fffff;
		else if (q < -37'sd8388608) r = 24'sh800000;
		else r = q[23:0];
		return r;
	endfunction

endpackage

// ===== sv/pcanc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCA projection nearest centroid channels
// Sample/command input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface pcanc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [11:0] entry_index;
	logic signed [23:0] entry_value;
	logic        last_element;
	modport source (output valid, command, entry_index, entry_value, last_element,
		input ready);
	modport sink (input valid, command, entry_index, entry_value, last_element,
		output ready);
endinterface

interface pcanc_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] cluster_label;
	logic       untrained;
	modport source (output valid, cluster_label, untrained, input ready);
	modport sink (input valid, cluster_label, untrained, output ready);
endinterface

interface pcanc_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [9:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/pcanc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pcanc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== sv/pcanc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCA projection nearest centroid front
// Accept words, saturate non-centroid values, range check addresses, push to the queue.
// ----------------------------------------------------------------------------
module pcanc_front import pcanc_pkg::*; #(
	parameter int MAX_DIMS       = DEF_MAX_DIMS,
	parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS,
	parameter int MAX_CLUSTERS   = DEF_MAX_CLUSTERS
) (
	pcanc_in_if.sink sample_in,
	input  cfg_t     cfg,
	input  logic     q_full,
	output logic     push,
	output op_t      push_op
);
	localparam int WDEPTH = MAX_COMPONENTS * MAX_DIMS;
	localparam int CDEPTH = MAX_CLUSTERS * MAX_COMPONENTS;

	cmd_t cmd;
	logic keep;
	logic [31:0] idx32;

	assign cmd   = cmd_t'(sample_in.command);
	assign idx32 = 32'(sample_in.entry_index);

	always_comb begin
		push_op.kind     = cmd;
		push_op.addr     = sample_in.entry_index;
		push_op.last     = sample_in.last_element;
		push_op.in_range = (idx32 < 32'(cfg.dims)) && (idx32 < 32'(MAX_DIMS));
		push_op.data     = 24'(sat16(sample_in.entry_value));
		keep             = 1'b1;
		case (cmd)
			CMD_MEAN:   keep = idx32 < 32'(MAX_DIMS);
			CMD_WEIGHT: keep = idx32 < 32'(WDEPTH);
			CMD_CENT: begin
				keep         = idx32 < 32'(CDEPTH);
				push_op.data = sample_in.entry_value;
			end
			CMD_SAMPLE: keep = 1'b1;
			default:    keep = 1'b0;
		endcase
	end

	// Drop out-of-range loads here; they never reach the back.
	assign sample_in.ready = !q_full;
	assign push = sample_in.valid && !q_full && keep;
endmodule

// ===== sv/pcanc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCA projection nearest centroid queue
// Two-word queue between front and back.
// ----------------------------------------------------------------------------
module pcanc_queue import pcanc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	input  logic pop,
	output logic full,
	output logic empty,
	output op_t  head
);
	op_t        mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// ===== sv/pcanc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCA projection nearest centroid back
// Table writes, projection accumulate, rounding and nearest centroid search.
// ----------------------------------------------------------------------------
module pcanc_back import pcanc_pkg::*; #(
	parameter int MAX_DIMS       = DEF_MAX_DIMS,
	parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS,
	parameter int MAX_CLUSTERS   = DEF_MAX_CLUSTERS
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic q_empty,
	input  op_t  head,
	output logic pop,
	pcanc_out_if.source result_out
);
	localparam int WDEPTH = MAX_COMPONENTS * MAX_DIMS;
	localparam int CDEPTH = MAX_CLUSTERS * MAX_COMPONENTS;
	localparam int MAW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int WAW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
	localparam int CAW = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
	localparam int CIW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
	localparam int CNW = $clog2(MAX_COMPONENTS + 1);
	localparam int KNW = $clog2(MAX_CLUSTERS + 1);
	localparam int DW  = 50 + CNW;

	typedef enum logic [3:0] {
		B_IDLE, B_RDM, B_DIFF, B_MUL, B_ACC, B_RDW, B_END,
		B_ROUND, B_CRD, B_SQ, B_CAC, B_EMIT
	} state_t;

	state_t state_q;

	logic [CNW-1:0] ncomp;
	logic [KNW-1:0] nclus;
	assign ncomp = (32'(cfg.comps) > 32'(MAX_COMPONENTS)) ?
		CNW'(MAX_COMPONENTS) : CNW'(cfg.comps);
	assign nclus = (32'(cfg.clusters) > 32'(MAX_CLUSTERS)) ?
		KNW'(MAX_CLUSTERS) : KNW'(cfg.clusters);

	// Tables
	logic m_we, w_we, c_we;
	logic [15:0] m_rdata, w_rdata;
	logic [23:0] c_rdata;
	logic [IDX_W-1:0] addr_q;
	logic [WAW-1:0]   w_addr_q;
	logic [CAW:0]     caddr_q;
	logic [CAW:0]     base_q;

	assign pop  = (state_q == B_IDLE) && !q_empty;
	assign m_we = pop && (head.kind == CMD_MEAN);
	assign w_we = pop && (head.kind == CMD_WEIGHT);
	assign c_we = pop && (head.kind == CMD_CENT);

	pcanc_ram #(.WIDTH(16), .DEPTH(MAX_DIMS)) u_mean (
		.clk(clk), .we(m_we), .waddr(MAW'(head.addr)), .wdata(head.data[15:0]),
		.raddr(MAW'(addr_q)), .rdata(m_rdata));

	pcanc_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_weight (
		.clk(clk), .we(w_we), .waddr(WAW'(head.addr)), .wdata(head.data[15:0]),
		.raddr(w_addr_q), .rdata(w_rdata));

	pcanc_ram #(.WIDTH(24), .DEPTH(CDEPTH)) u_cent (
		.clk(clk), .we(c_we), .waddr(CAW'(head.addr)), .wdata(head.data),
		.raddr(caddr_q[CAW-1:0]), .rdata(c_rdata));

	// Datapath registers
	logic signed [15:0] val_q;
	logic               last_q;
	logic signed [16:0] diff_s1;
	logic signed [32:0] prod_s2;
	logic signed [47:0] sum_q [MAX_COMPONENTS];
	logic signed [23:0] proj_q [MAX_COMPONENTS];
	logic [49:0]        sq_s2;
	logic [DW-1:0]      dist_q;
	logic [DW-1:0]      best_dist_q;
	logic [KNW-1:0]     best_q;
	logic [KNW-1:0]     k_q;
	logic [CNW-1:0]     c_q;
	logic               model_ready_q;
	logic               out_vld_q;
	logic [2:0]         label_q;
	logic               untrained_q;
	logic [2:0]         res_label_q;
	logic               res_untrained_q;

	logic signed [48:0] acc_sum;
	logic signed [47:0] acc_sat;
	logic signed [24:0] cdiff;
	logic [DW-1:0]      dist_n;
	logic signed [23:0] proj_n [MAX_COMPONENTS];
	logic [KNW-1:0]     best_n;

	assign acc_sum = 49'(sum_q[c_q[CIW-1:0]]) + 49'(prod_s2);
	assign acc_sat = (acc_sum > 49'sh7fffffffffff) ? 48'sh7fffffffffff :
		(acc_sum < -49'sh800000000000) ? 48'sh800000000000 : acc_sum[47:0];
	assign cdiff  = 25'(proj_q[c_q[CIW-1:0]]) - 25'($signed(c_rdata));
	assign dist_n = dist_q + DW'(sq_s2);
	assign best_n = ((k_q == '0) || (dist_n < best_dist_q)) ? k_q : best_q;

	always_comb begin
		for (int i = 0; i < MAX_COMPONENTS; i++) begin
			proj_n[i] = to_q11_12(sum_q[i]);
		end
	end

	assign result_out.valid         = out_vld_q;
	assign result_out.cluster_label = res_label_q;
	assign result_out.untrained     = res_untrained_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_IDLE;
			model_ready_q <= 1'b0;
			out_vld_q     <= 1'b0;
			for (int i = 0; i < MAX_COMPONENTS; i++) begin
				sum_q[i] <= '0;
			end
		end else begin
			if (out_vld_q && result_out.ready && state_q != B_EMIT) out_vld_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						addr_q   <= head.addr;
						w_addr_q <= WAW'(head.addr);
						val_q    <= head.data[15:0];
						last_q   <= head.last;
						c_q      <= '0;
						if (head.kind == CMD_CENT) model_ready_q <= 1'b1;
						if (head.kind == CMD_SAMPLE) begin
							state_q <= head.in_range ? B_RDM : B_END;
						end
					end
				end
				B_RDM: state_q <= B_DIFF;
				B_DIFF: begin
					diff_s1 <= 17'(val_q) - 17'($signed(m_rdata));
					state_q <= (ncomp == '0) ? B_END : B_MUL;
				end
				B_MUL: begin
					prod_s2 <= diff_s1 * 33'($signed(w_rdata));
					state_q <= B_ACC;
				end
				B_ACC: begin
					sum_q[c_q[CIW-1:0]] <= acc_sat;
					c_q      <= c_q + 1'b1;
					w_addr_q <= w_addr_q + WAW'(MAX_DIMS);
					state_q  <= (c_q + 1'b1 < ncomp) ? B_RDW : B_END;
				end
				B_RDW: state_q <= B_MUL;
				B_END: state_q <= last_q ? B_ROUND : B_IDLE;
				B_ROUND: begin
					for (int i = 0; i < MAX_COMPONENTS; i++) begin
						proj_q[i] <= proj_n[i];
						sum_q[i]  <= '0;
					end
					c_q     <= '0;
					k_q     <= '0;
					caddr_q <= '0;
					base_q  <= '0;
					dist_q  <= '0;
					best_q  <= '0;
					label_q <= '0;
					untrained_q <= !model_ready_q;
					if (!model_ready_q || nclus == '0 || ncomp == '0) begin
						state_q <= B_EMIT;
					end else begin
						state_q <= B_CRD;
					end
				end
				B_CRD: state_q <= B_SQ;
				B_SQ: begin
					sq_s2   <= 50'(cdiff * cdiff);
					state_q <= B_CAC;
				end
				B_CAC: begin
					if (c_q + 1'b1 < ncomp) begin
						dist_q  <= dist_n;
						c_q     <= c_q + 1'b1;
						caddr_q <= caddr_q + 1'b1;
						state_q <= B_CRD;
					end else begin
						// Cluster done: keep the strictly smaller distance.
						best_q      <= best_n;
						best_dist_q <= (best_n == k_q) ? dist_n : best_dist_q;
						dist_q      <= '0;
						c_q         <= '0;
						k_q         <= k_q + 1'b1;
						base_q      <= base_q + (CAW+1)'(MAX_COMPONENTS);
						caddr_q     <= base_q + (CAW+1)'(MAX_COMPONENTS);
						if (k_q + 1'b1 < nclus) begin
							state_q <= B_CRD;
						end else begin
							label_q <= 3'(best_n);
							state_q <= B_EMIT;
						end
					end
				end
				B_EMIT: begin
					// Load the result register only once the previous word is gone.
					if (!out_vld_q || result_out.ready) begin
						out_vld_q       <= 1'b1;
						res_label_q     <= label_q;
						res_untrained_q <= untrained_q;
						state_q         <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/pca_project_nearest_centroid_unit.sv =====
`timescale 1ns / 1ps
// A load is queued, then written to its table when the back pops it. A sample element
//   in range adds its weighted difference from the mean into each configured component sum.
// A last element then rounds, searches the centroids if trained and emits the result word.
// Throughput: one word per back operation; the two-word queue lets the input side
//   keep accepting while the back is busy or a result waits to be taken.
// Reset clears control state and the model-ready flag; tables are undefined.
// ----------------------------------------------------------------------------
// PCA projection nearest centroid unit
// Projects streamed embeddings onto loaded components and labels the nearest
// centroid.
// ----------------------------------------------------------------------------
module pca_project_nearest_centroid_unit import pcanc_pkg::*; #(
	parameter int MAX_DIMS       = DEF_MAX_DIMS,
	parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS,
	parameter int MAX_CLUSTERS   = DEF_MAX_CLUSTERS
) (
	input logic           clk,
	input logic           arst_n,
	pcanc_in_if.sink      sample_in,
	pcanc_out_if.source   result_out,
	pcanc_cfg_if.sink     cfg
);
	cfg_t cfg_q;
	logic q_full, q_empty, push, pop;
	op_t  push_op, head;

	// Configuration words are always taken; unknown indexes are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dims     <= 10'd512;
			cfg_q.comps    <= 4'd8;
			cfg_q.clusters <= 4'd8;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_DIMS:     cfg_q.dims     <= cfg.data;
				CFG_COMPS:    cfg_q.comps    <= cfg.data[3:0];
				CFG_CLUSTERS: cfg_q.clusters <= cfg.data[3:0];
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	// Front: classify each accepted word and saturate all but centroid values.
	pcanc_front #(
		.MAX_DIMS(MAX_DIMS), .MAX_COMPONENTS(MAX_COMPONENTS),
		.MAX_CLUSTERS(MAX_CLUSTERS)
	) u_front (
		.sample_in(sample_in), .cfg(cfg_q), .q_full(q_full),
		.push(push), .push_op(push_op));

	// Queue: decouple the front from the back.
	pcanc_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_op(push_op),
		.pop(pop), .full(q_full), .empty(q_empty), .head(head));

	// Back: tables, accumulate, search, result register.
	pcanc_back #(
		.MAX_DIMS(MAX_DIMS), .MAX_COMPONENTS(MAX_COMPONENTS),
		.MAX_CLUSTERS(MAX_CLUSTERS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_empty(q_empty),
		.head(head), .pop(pop), .result_out(result_out));
endmodule

// ===== tb/pca_project_nearest_centroid_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCA projection nearest centroid unit testbench
// Loads the mean, weight and centroid tables through the sample channel. It
// then streams samples under several register settings. Each returned label
// is checked against a cycle-free model of the projection and the nearest
// centroid search. Both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
module pca_project_nearest_centroid_unit_tb;
	import pcanc_pkg::*;

	localparam int  HALF_PERIOD  = 6;
	localparam int  N_DIMS       = DEF_MAX_DIMS;
	localparam int  N_COMPS      = DEF_MAX_COMPONENTS;
	localparam int  N_CLUS       = DEF_MAX_CLUSTERS;
	localparam int  LOADED_DIMS  = 16;     // elements with mean and weights loaded
	localparam int  SETTLE       = 300;
	localparam int  HOLD_CYCLES  = 3000;
	localparam int  PHASE_ITEMS  = 135;
	localparam int  N_PHASES     = 7;
	localparam longint CYCLE_LIMIT = 1500000;
	localparam longint ACC_MAX   = 64'sh00007fffffffffff;
	localparam longint ACC_MIN   = -ACC_MAX - 1;
	localparam longint PROJ_MAX  = 64'sh00000000007fffff;
	localparam longint PROJ_MIN  = -PROJ_MAX - 1;

	typedef struct packed {
		logic [2:0] label;
		logic       untrained;
	} label_t;

	typedef struct packed {
		logic       late;     // row runs after the centroid table is loaded
		cmd_t       cmd;
		logic [11:0] idx;
		logic [23:0] val;
		logic       last;
		logic       typed;    // expected label written in the row
		logic [2:0] label;
		logic       untrained;
	} stim_row_t;

	localparam int N_ROWS = 19;
	localparam stim_row_t DIRECTED [N_ROWS] = '{
		// untrained: sample ends before any centroid is loaded
		'{1'b0, CMD_SAMPLE, 12'd4095, 24'h000000, 1'b1, 1'b1, 3'd0, 1'b1},
		'{1'b0, CMD_SAMPLE, 12'd0,    24'h7fffff, 1'b0, 1'b0, 3'd0, 1'b0},
		'{1'b0, CMD_SAMPLE, 12'd1,    24'h800000, 1'b1, 1'b1, 3'd0, 1'b1},
		// saturating loads, a last mark on a load, addresses out of range
		'{1'b0, CMD_MEAN,   12'd0,    24'h7fffff, 1'b1, 1'b0, 3'd0, 1'b0},
		'{1'b0, CMD_MEAN,   12'd1,    24'h800000, 1'b0, 1'b0, 3'd0, 1'b0},
		'{1'b0, CMD_MEAN,   12'd4095, 24'h123456, 1'b0, 1'b0, 3'd0, 1'b0},
		'{1'b0, CMD_WEIGHT, 12'd0,    24'h7fffff, 1'b0, 1'b0, 3'd0, 1'b0},
		'{1'b0, CMD_WEIGHT, 12'd512,  24'h800000, 1'b0, 1'b0, 3'd0, 1'b0},
		'{1'b0, CMD_WEIGHT, 12'd4095, 24'h000abc, 1'b1, 1'b0, 3'd0, 1'b0},
		'{1'b0, CMD_CENT,   12'd4095, 24'h7fffff, 1'b0, 1'b0, 3'd0, 1'b0},
		'{1'b0, CMD_SAMPLE, 12'd2,    24'h000100, 1'b1, 1'b1, 3'd0, 1'b1},
		// trained: extremes of sample values and centroids
		'{1'b1, CMD_SAMPLE, 12'd0,    24'h7fffff, 1'b0, 1'b0, 3'd0, 1'b0},
		'{1'b1, CMD_SAMPLE, 12'd1,    24'h7fffff, 1'b1, 1'b0, 3'd0, 1'b0},
		'{1'b1, CMD_SAMPLE, 12'd0,    24'h800000, 1'b1, 1'b0, 3'd0, 1'b0},
		'{1'b1, CMD_CENT,   12'd0,    24'h7fffff, 1'b0, 1'b0, 3'd0, 1'b0},
		'{1'b1, CMD_CENT,   12'd63,   24'h800000, 1'b0, 1'b0, 3'd0, 1'b0},
		'{1'b1, CMD_SAMPLE, 12'd15,   24'h7fffff, 1'b0, 1'b0, 3'd0, 1'b0},
		'{1'b1, CMD_SAMPLE, 12'd3000, 24'h5a5a5a, 1'b1, 1'b0, 3'd0, 1'b0},
		'{1'b1, CMD_SAMPLE, 12'd0,    24'h000000, 1'b1, 1'b0, 3'd0, 1'b0}
	};

	logic clk;
	logic arst_n;

	pcanc_in_if  smp ();
	pcanc_out_if res ();
	pcanc_cfg_if cfg_ch ();

	pca_project_nearest_centroid_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_in  (smp),
		.result_out (res),
		.cfg        (cfg_ch)
	);

	// Model state: tables, running sums and register copies.
	logic signed [15:0] mean_tbl   [N_DIMS];
	logic signed [15:0] weight_tbl [N_COMPS*N_DIMS];
	logic signed [23:0] cent_tbl   [N_CLUS*N_COMPS];
	longint             proj_acc   [N_COMPS];
	bit                 trained;
	int unsigned        dims_reg, comps_reg, clus_reg;

	label_t  expected_labels[$];
	int      mismatches;
	longint  cycles;
	bit      hold_req;
	bit      sender_idle_on;

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Run limit: fail rather than hang.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic signed [15:0] clip16(input logic signed [23:0] v);
		if (v > 24'sd32767) return 16'sh7fff;
		if (v < -24'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic int unsigned capped(input int unsigned v, input int unsigned m);
		return (v > m) ? m : v;
	endfunction

	// Advance the model by one accepted word; report a label on a sample end.
	task automatic classify_word(input cmd_t cmd, input logic [11:0] idx,
			input logic signed [23:0] val, input logic last,
			output bit has_label, output label_t lbl);
		int unsigned ncomp, nclus, best;
		longint diff, s, t, q, d;
		longint proj [N_COMPS];
		longint unsigned sq_total, best_total;
		has_label = 1'b0;
		lbl = '0;
		ncomp = capped(comps_reg, N_COMPS);
		nclus = capped(clus_reg, N_CLUS);
		case (cmd)
			CMD_MEAN: begin
				if (idx < N_DIMS) mean_tbl[idx] = clip16(val);
			end
			CMD_WEIGHT: begin
				if (idx < N_COMPS*N_DIMS) weight_tbl[idx] = clip16(val);
			end
			CMD_CENT: begin
				if (idx < N_CLUS*N_COMPS) begin
					cent_tbl[idx] = val;
					trained = 1'b1;
				end
			end
			default: begin
				if (idx < capped(dims_reg, N_DIMS)) begin
					diff = longint'(clip16(val)) - longint'(mean_tbl[idx]);
					for (int c = 0; c < ncomp; c++) begin
						s = proj_acc[c] + diff * longint'(weight_tbl[c*N_DIMS + idx]);
						if (s > ACC_MAX) s = ACC_MAX;
						if (s < ACC_MIN) s = ACC_MIN;
						proj_acc[c] = s;
					end
				end
				if (last) begin
					has_label = 1'b1;
					// round half up to Q11.12 and clear the sums
					for (int c = 0; c < N_COMPS; c++) begin
						t = proj_acc[c] + 2048;
						q = t >>> 12;
						if (q > PROJ_MAX) q = PROJ_MAX;
						if (q < PROJ_MIN) q = PROJ_MIN;
						proj[c] = q;
						proj_acc[c] = 0;
					end
					if (trained) begin
						best = 0;
						best_total = 0;
						for (int k = 0; k < nclus; k++) begin
							sq_total = 0;
							for (int c = 0; c < ncomp; c++) begin
								d = proj[c] - longint'(cent_tbl[k*N_COMPS + c]);
								sq_total += longint'(d * d);
							end
							// strict compare keeps ties on the lower index
							if (k == 0 || sq_total < best_total) begin
								best_total = sq_total;
								best = k;
							end
						end
						lbl.label = best[2:0];
						lbl.untrained = 1'b0;
					end else begin
						lbl.label = 3'd0;
						lbl.untrained = 1'b1;
					end
				end
			end
		endcase
	endtask

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// About half in Q4.12 range, some extremes, some full 24-bit words.
	function automatic logic [23:0] rand_value();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 24'h7fffff;
		if (r == 1) return 24'h800000;
		if (r < 5) return 24'($urandom);
		return {{8{1'b0}}, 16'($urandom)} ^ (($urandom_range(0, 1) == 1) ? 24'hff0000 : 24'h0);
	endfunction

	// Positions that read only loaded mean and weight entries.
	function automatic logic [11:0] pick_position();
		int unsigned p;
		do begin
			if ($urandom_range(0, 9) < 8) p = $urandom_range(0, LOADED_DIMS-1);
			else p = $urandom_range(0, 4095);
		end while (!(p < LOADED_DIMS || p >= capped(dims_reg, N_DIMS)));
		return p[11:0];
	endfunction

	// Offer one word, wait for acceptance, then update the model.
	task automatic send_word(input cmd_t cmd, input logic [11:0] idx,
			input logic [23:0] val, input logic last,
			input bit typed, input label_t typed_lbl);
		bit has_label;
		label_t lbl;
		int gap;
		smp.valid        <= 1'b1;
		smp.command      <= cmd;
		smp.entry_index  <= idx;
		smp.entry_value  <= val;
		smp.last_element <= last;
		do @(posedge clk); while (!smp.ready);
		classify_word(cmd, idx, val, last, has_label, lbl);
		if (has_label)
			expected_labels.insert(expected_labels.size(), typed ? typed_lbl : lbl);
		gap = sender_idle_on ? idle_gap() : 0;
		if (gap > 0) begin
			smp.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold until every label is back and the back stage has settled.
	task automatic drain();
		smp.valid <= 1'b0;
		@(posedge clk);
		while (expected_labels.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [9:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			CFG_DIMS:     dims_reg  = 32'(data);
			CFG_COMPS:    comps_reg = 32'(data[3:0]);
			CFG_CLUSTERS: clus_reg  = 32'(data[3:0]);
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic configure(input logic [9:0] dims, input logic [9:0] comps,
			input logic [9:0] clus);
		drain();
		write_reg(CFG_DIMS, dims);
		write_reg(CFG_COMPS, comps);
		write_reg(CFG_CLUSTERS, clus);
	endtask

	// Result side: random stalls, idle-free stretches, one long hold-off.
	initial begin
		int stall;
		bit stalls_on;
		res.ready <= 1'b0;
		stall = 0;
		stalls_on = 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (cycles % 256 == 0) stalls_on = ($urandom_range(0, 3) != 0);
			if (hold_req) begin
				hold_req = 1'b0;
				res.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (stall > 0) begin
				stall--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
				if (stalls_on && $urandom_range(0, 4) == 0) stall = idle_gap();
			end
		end
	end

	// Check each accepted result word against the oldest expectation.
	always @(posedge clk) begin
		label_t want;
		if (arst_n && res.valid && res.ready) begin
			if (expected_labels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: label %0d untrained %0b",
						res.cluster_label, res.untrained);
			end else begin
				want = expected_labels.pop_front();
				if (res.cluster_label !== want.label || res.untrained !== want.untrained) begin
					mismatches++;
					if (mismatches <= 10)
						$display("label mismatch: expected %0d/%0b, got %0d/%0b",
							want.label, want.untrained, res.cluster_label, res.untrained);
				end
			end
		end
	end

	initial begin
		label_t none;
		int len, sent, r, c, i;
		logic [9:0] pd, pc, pk;
		none = '0;
		mismatches = 0;
		cycles = 0;
		hold_req = 1'b0;
		sender_idle_on = 1'b1;
		dims_reg = N_DIMS;
		comps_reg = N_COMPS;
		clus_reg = N_CLUS;
		trained = 1'b0;
		foreach (proj_acc[j]) proj_acc[j] = 0;
		arst_n = 1'b0;
		smp.valid = 1'b0;
		smp.command = CMD_MEAN;
		smp.entry_index = '0;
		smp.entry_value = '0;
		smp.last_element = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_NONE;
		cfg_ch.data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load mean and all component weights for the low elements.
		for (i = 0; i < LOADED_DIMS; i++)
			send_word(CMD_MEAN, 12'(i), rand_value(), 1'b0, 0, none);
		for (c = 0; c < N_COMPS; c++)
			for (i = 0; i < LOADED_DIMS; i++)
				send_word(CMD_WEIGHT, 12'(c*N_DIMS + i), rand_value(), 1'b0, 0, none);

		for (r = 0; r < N_ROWS; r++) begin
			if (!DIRECTED[r].late)
				send_word(DIRECTED[r].cmd, DIRECTED[r].idx, DIRECTED[r].val,
					DIRECTED[r].last, DIRECTED[r].typed,
					'{DIRECTED[r].label, DIRECTED[r].untrained});
		end
		// Fill the centroid table; this trains the model.
		for (i = 0; i < N_CLUS*N_COMPS; i++)
			send_word(CMD_CENT, 12'(i), 24'($signed(24'($urandom)) >>> $urandom_range(0, 8)),
				1'($urandom_range(0, 1)), 0, none);
		for (r = 0; r < N_ROWS; r++) begin
			if (DIRECTED[r].late)
				send_word(DIRECTED[r].cmd, DIRECTED[r].idx, DIRECTED[r].val,
					DIRECTED[r].last, DIRECTED[r].typed,
					'{DIRECTED[r].label, DIRECTED[r].untrained});
		end

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: begin pd = 16;   pc = 8;  pk = 8;  end
				1: begin pd = 1;    pc = 1;  pk = 1;  end
				2: begin pd = 0;    pc = 0;  pk = 0;  end
				3: begin pd = 1023; pc = 15; pk = 15; end
				4: begin pd = 512;  pc = 8;  pk = 8;  end
				5: begin
					pd = 10'($urandom_range(1, LOADED_DIMS));
					pc = 10'($urandom);
					pk = 10'($urandom);
				end
				default: begin pd = 7; pc = 3; pk = 5; end
			endcase
			// pause the sender until everything is back, then reconfigure
			configure(pd, pc, pk);
			sender_idle_on = (ph % 3 != 2);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if (ph == 0 && sent == 20) hold_req = 1'b1;
				r = $urandom_range(0, 99);
				if (r < 75) begin
					// sample: positions mostly in order, some picked at random, last on the final one
					len = $urandom_range(1, capped(dims_reg, LOADED_DIMS) + 2);
					for (i = 0; i < len; i++) begin
						send_word(CMD_SAMPLE,
							(i < LOADED_DIMS && $urandom_range(0, 7) != 0) ? 12'(i)
								: pick_position(),
							rand_value(), i == len - 1, 0, none);
						sent++;
					end
				end else if (r < 90) begin
					// reload a table entry in the loaded region
					case ($urandom_range(0, 2))
						0: send_word(CMD_MEAN, 12'($urandom_range(0, LOADED_DIMS-1)),
							rand_value(), 1'($urandom_range(0, 1)), 0, none);
						1: send_word(CMD_WEIGHT,
							12'($urandom_range(0, N_COMPS-1)*N_DIMS +
								$urandom_range(0, LOADED_DIMS-1)),
							rand_value(), 1'($urandom_range(0, 1)), 0, none);
						default: send_word(CMD_CENT,
							12'($urandom_range(0, N_CLUS*N_COMPS-1)),
							24'($urandom), 1'($urandom_range(0, 1)), 0, none);
					endcase
					sent++;
				end else begin
					// noise: dropped loads and stray sample elements
					case ($urandom_range(0, 2))
						0: send_word(CMD_MEAN, 12'($urandom_range(N_DIMS, 4095)),
							24'($urandom), 1'($urandom_range(0, 1)), 0, none);
						1: send_word(CMD_CENT, 12'($urandom_range(N_CLUS*N_COMPS, 4095)),
							24'($urandom), 1'($urandom_range(0, 1)), 0, none);
						default: send_word(CMD_SAMPLE, pick_position(), 24'($urandom),
							1'($urandom_range(0, 1)), 0, none);
					endcase
					sent++;
				end
			end
		end

		drain();
		if (expected_labels.size() != 0) mismatches++;
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
